FILE: hw/rtl/hbsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hbsf_pkg;

    // Line codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // CRC-16, x^16 + x^12 + x^5 + 1, MSB first
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One classified input word as it waits for the serializer
    typedef struct packed {
        logic        open;   // frame opens with this word: send opening flag
        logic        last;   // frame closes: send CRC and closing flag
        logic [7:0]  data;
        logic [15:0] crc;    // CRC including this data byte
    } t_entry;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // Serializer steps, one line byte each
    typedef enum logic [2:0] {
        ST_OPEN,
        ST_DATA,
        ST_DATA_ESC,
        ST_CRC_HI,
        ST_CRC_HI_ESC,
        ST_CRC_LO,
        ST_CRC_LO_ESC,
        ST_CLOSE
    } t_step;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == ESC_BYTE) || (b == FLAG_BYTE);
    endfunction

    // Byte-wide CRC update, eight shifts of a 16-bit value
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hbsf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hbsf_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_frame_last,
    input  wire hbsf_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output hbsf_pkg::t_entry     o_entry
);
    import hbsf_pkg::*;

    logic        r_in_frame;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        w_accept;
    logic [15:0] w_crc_base;

    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;

    // classify the word and fold its byte into the CRC
    assign w_crc_base = r_in_frame ? r_crc : CRC_INIT;
    assign n_crc      = crc_byte(w_crc_base, i_data_byte);

    assign o_push        = w_accept;
    assign o_entry.open  = !r_in_frame;
    assign o_entry.last  = i_frame_last;
    assign o_entry.data  = i_data_byte;
    assign o_entry.crc   = n_crc;

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_crc      <= CRC_INIT;
        end else if (w_accept) begin
            if (i_frame_last) begin
                r_in_frame <= 1'b0;
                r_crc      <= CRC_INIT;
            end else begin
                r_in_frame <= 1'b1;
                r_crc      <= n_crc;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hbsf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hbsf_queue #(
    parameter int DEPTH = hbsf_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire hbsf_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output hbsf_pkg::t_entry      o_entry,
    output hbsf_pkg::t_q_stat     o_stat
);
    import hbsf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_stat.full      = (r_cnt == FULL_CNT);
    assign o_stat.not_empty = (r_cnt != '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && o_stat.not_empty;
    assign o_entry = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hbsf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hbsf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hbsf_pkg::t_entry  i_entry,
    input  wire hbsf_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_line_byte,
    output logic                   o_run_last,
    output logic                   o_frame_done
);
    import hbsf_pkg::*;

    // current word being serialized
    t_entry      r_ent;
    logic        r_busy;
    t_step       r_step;
    t_step       n_step;

    // output register
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_odone;

    logic        w_out_free;
    logic        w_emit;
    logic        w_end;
    logic [7:0]  w_byte;
    logic [7:0]  w_crc_hi;
    logic [7:0]  w_crc_lo;

    assign w_crc_hi   = r_ent.crc[15:8];
    assign w_crc_lo   = r_ent.crc[7:0];
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_emit     = r_busy && w_out_free;
    assign o_pop      = i_q_stat.not_empty && (!r_busy || (w_emit && w_end));

    // byte for this step and the step after it
    always_comb begin
        w_byte = r_ent.data;
        w_end  = 1'b0;
        n_step = r_step;
        unique case (r_step)
            ST_OPEN: begin
                w_byte = FLAG_BYTE;
                n_step = ST_DATA;
            end
            ST_DATA: begin
                w_byte = needs_esc(r_ent.data) ? ESC_BYTE : r_ent.data;
                if (needs_esc(r_ent.data)) begin
                    n_step = ST_DATA_ESC;
                end else if (r_ent.last) begin
                    n_step = ST_CRC_HI;
                end else begin
                    w_end = 1'b1;
                end
            end
            ST_DATA_ESC: begin
                w_byte = r_ent.data ^ ESC_XOR;
                if (r_ent.last) begin
                    n_step = ST_CRC_HI;
                end else begin
                    w_end = 1'b1;
                end
            end
            ST_CRC_HI: begin
                w_byte = needs_esc(w_crc_hi) ? ESC_BYTE : w_crc_hi;
                n_step = needs_esc(w_crc_hi) ? ST_CRC_HI_ESC : ST_CRC_LO;
            end
            ST_CRC_HI_ESC: begin
                w_byte = w_crc_hi ^ ESC_XOR;
                n_step = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                w_byte = needs_esc(w_crc_lo) ? ESC_BYTE : w_crc_lo;
                n_step = needs_esc(w_crc_lo) ? ST_CRC_LO_ESC : ST_CLOSE;
            end
            ST_CRC_LO_ESC: begin
                w_byte = w_crc_lo ^ ESC_XOR;
                n_step = ST_CLOSE;
            end
            ST_CLOSE: begin
                w_byte = FLAG_BYTE;
                w_end  = 1'b1;
            end
            default: begin
                w_byte = r_ent.data;
            end
        endcase
    end

    // word load from the queue
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    // step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_OPEN;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_step <= i_entry.open ? ST_OPEN : ST_DATA;
        end else if (w_emit) begin
            r_busy <= !w_end;
            r_step <= n_step;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_free) begin
            r_ovalid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obyte <= w_byte;
            r_olast <= w_end;
            r_odone <= (r_step == ST_CLOSE);
        end
    end

    assign o_valid      = r_ovalid;
    assign o_line_byte  = r_obyte;
    assign o_run_last   = r_olast;
    assign o_frame_done = r_odone;

endmodule

`default_nettype wire

FILE: hw/rtl/hdlc_byte_stuff_framer_crc16.sv
// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+-----------------------------------------
// in      | input     | i_in_valid / o_in_stall | i_data_byte, i_frame_last
// out     | output    | o_out_valid/i_out_stall | o_line_byte, o_run_last, o_frame_done
//
// While output is not stalled, the serializer sends one line byte per cycle; a word gives
// 1 to 8 (opening flag, data with escape, two CRC bytes with escapes, closing flag).
// A plain in-frame data byte gives one line byte, so such words pass at one a cycle too.
// Input stalls only when the classify queue is full; output stall holds the output register.
// Reset is synchronous, active low: clears frame state, CRC, queue and output valid.
// A word passes the queue, word register and output register before its first line byte.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_byte_stuff_framer_crc16 #(
    parameter int QUEUE_DEPTH = hbsf_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_frame_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_line_byte,
    output logic            o_run_last,
    output logic            o_frame_done
);
    import hbsf_pkg::*;

    t_q_stat w_q_stat;
    t_entry  w_push_entry;
    t_entry  w_head_entry;
    logic    w_push;
    logic    w_pop;

    // classify and CRC
    hbsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_frame_last (i_frame_last),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    // decoupling queue
    hbsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_q_stat)
    );

    // byte serializer
    hbsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (w_head_entry),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_line_byte  (o_line_byte),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/hbsf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hbsf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_data_byte,
    input wire logic       i_frame_last,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_line_byte,
    input wire logic       o_run_last,
    input wire logic       o_frame_done
);
    import hbsf_pkg::*;

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_data_byte)
            && $stable(i_frame_last))
        else $error("input word changed under stall");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_line_byte)
            && $stable(o_run_last) && $stable(o_frame_done))
        else $error("output word changed under stall");

    // closing flag ends the run of its input word
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_run_last)
        else $error("closing flag without run_last");

    // closing flag carries the flag code
    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_line_byte == FLAG_BYTE)
        else $error("frame_done on a non-flag byte");

    // reset empties the output register
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind hdlc_byte_stuff_framer_crc16 hbsf_checker u_hbsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_data_byte  (i_data_byte),
    .i_frame_last (i_frame_last),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_line_byte  (o_line_byte),
    .o_run_last   (o_run_last),
    .o_frame_done (o_frame_done)
);

`default_nettype wire
